[hdl/bra_pkg.sv]
`timescale 1ns / 1ps

package bra_pkg;

  localparam int MAP_BITS        = 1024;
  localparam int WORD_BITS       = 64;
  localparam int BUDDY_MAX_BLOCK = 512;
  localparam int MAP_WORDS       = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int OFF_W           = $clog2(WORD_BITS);
  localparam int WA_W            = $clog2(MAP_WORDS);

  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 12;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_BUDDY = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_BITS   = 1'b1;

  // smallest power of two not below c, for c up to the buddy limit
  function automatic logic [CNT_W-1:0] round_pow2(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = CNT_W'(1);
    for (int k = 0; k < CNT_W - 1; k++) begin
      if (c > (CNT_W'(1) << k)) r = CNT_W'(1) << (k + 1);
    end
    return r;
  endfunction

endpackage

[hdl/bitmap_run_allocator.sv]
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_       in   tvalid/tready      tuser: command; tdata: start_index, run_length, target_value
// out_      out  tvalid/tready      tdata: found_index, status, bit_value
// cfg_      in   wr_en              index 0 alloc_policy, 1 bits_in_use
//
// one request at a time; the map is scanned one bit per cycle out of a
// registered word, with a read and a load state for each word read from the
// map ram. an allocate pass scans up to the valid bits, next fit may need a
// second pass from zero, and inverting the run takes a read and a write state
// per word touched; a test reads the word that holds its bit and returns it.
// rst_n is synchronous; per-word valid bits make the map read as zero after
// reset, so there is no clearing pass. a finished result waits in the output
// register while the next request is taken.

module bitmap_run_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command
  input  logic [23:0] in_tdata,   // start_index[10:0], run_length[21:11], target_value[22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_index[9:0], status[11:10], bit_value[12]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int CW = bra_pkg::CNT_W;
  localparam int PW = bra_pkg::POS_W;
  localparam int OW = bra_pkg::OFF_W;
  localparam int AW = bra_pkg::WA_W;
  localparam int WB = bra_pkg::WORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_LD   = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_SEND = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WMOD = 4'd7;
  localparam logic [3:0] S_TRD  = 4'd8;
  localparam logic [3:0] S_TLD  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]    state_r;
  logic [1:0]    policy_r;
  logic [CW-1:0] bits_r;
  logic [CW-1:0] ptr_r;

  logic [1:0]    cmd_r;
  logic [CW-1:0] st_r, cnt_r, len_r;
  logic          v_r;

  logic [PW-1:0] p_r;
  logic [CW-1:0] c_r, best_r;
  logic [CW-1:0] best_idx_r;
  logic          found_r, blk_ok_r, phase2_r;
  logic [WB-1:0] wreg_r;

  logic [CW-1:0] wr_s_r, wr_e_r;
  logic [AW-1:0] wp_r;
  logic          wr_val_r;

  logic [bra_pkg::IDX_W-1:0] res_idx_r;
  logic [1:0]                res_status_r;
  logic                      res_bit_r;
  logic                      out_valid_r;
  logic [15:0]               out_data_r;

  // map ram with row valid bits
  logic [WB-1:0]        mem [bra_pkg::MAP_WORDS];
  logic [bra_pkg::MAP_WORDS-1:0] row_valid_r;
  logic [WB-1:0]        q_r;
  logic                 qv_r;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic [WB-1:0]        mem_wd;

  // derived values
  logic [CW-1:0] n_eff;
  logic [CW-1:0] rnd;
  logic [PW-1:0] aligned;
  logic          bitm, match;
  logic [PW-1:0] p_inc;
  logic [CW-1:0] c_inc, run_r;
  logic [PW-1:0] hit_s, run_s;
  logic [CW-1:0] off;
  logic          ok_n;
  logic [OW-1:0] lo_off, hi_off;
  logic [WB-1:0] wmask, rd_word;
  logic [CW:0]   nf_end;

  assign n_eff   = (bits_r > CW'(bra_pkg::MAP_BITS)) ? CW'(bra_pkg::MAP_BITS) : bits_r;
  assign rnd     = bra_pkg::round_pow2(cnt_r);
  assign aligned = (PW'(st_r) + PW'(rnd) - PW'(1)) & ~(PW'(rnd) - PW'(1));

  assign bitm    = wreg_r[p_r[OW-1:0]];
  assign match   = (bitm == v_r);
  assign p_inc   = p_r + PW'(1);
  assign c_inc   = c_r + CW'(1);
  assign hit_s   = p_inc - PW'(len_r);
  assign run_r   = match ? c_inc : c_r;
  assign run_s   = (match ? p_inc : p_r) - PW'(run_r);
  assign off     = p_r[CW-1:0] & (len_r - CW'(1));
  assign ok_n    = ((off == '0) ? 1'b1 : blk_ok_r) & match;
  assign nf_end  = {1'b0, hit_s[CW-1:0]} + {1'b0, len_r};

  assign rd_word = qv_r ? q_r : '0;
  assign lo_off  = (wp_r == wr_s_r[OW+AW-1:OW]) ? wr_s_r[OW-1:0] : '0;
  assign hi_off  = (wp_r == wr_e_r[OW+AW-1:OW]) ? wr_e_r[OW-1:0] : OW'(WB - 1);
  assign wmask   = ({WB{1'b1}} << lo_off) & ({WB{1'b1}} >> (OW'(WB - 1) - hi_off));

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = (rd_word & ~wmask) | (wr_val_r ? wmask : '0);
    mem_addr = p_r[OW+AW-1:OW];
    unique case (state_r)
      S_WRD:  mem_addr = wp_r;
      S_WMOD: begin
        mem_addr = wp_r;
        mem_we   = 1'b1;
      end
      S_TRD:  mem_addr = st_r[OW+AW-1:OW];
      default: mem_addr = p_r[OW+AW-1:OW];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    q_r  <= mem[mem_addr];
    qv_r <= row_valid_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (mem_we) begin
      row_valid_r[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= bra_pkg::POL_FIRST;
      bits_r   <= CW'(1024);
    end else if (cfg_wr_en) begin
      if (cfg_index == bra_pkg::CFG_POLICY) policy_r <= cfg_wdata[1:0];
      else                                  bits_r   <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {3'b000, res_bit_r, res_status_r, res_idx_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            st_r    <= in_tdata[10:0];
            cnt_r   <= in_tdata[21:11];
            v_r     <= in_tdata[22];
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          res_idx_r    <= '0;
          res_bit_r    <= 1'b0;
          res_status_r <= bra_pkg::ST_OK;
          c_r          <= '0;
          found_r      <= 1'b0;
          blk_ok_r     <= 1'b0;
          phase2_r     <= 1'b0;
          unique case (cmd_r)
            bra_pkg::CMD_ALLOC: begin
              len_r <= (policy_r == bra_pkg::POL_BUDDY) ? rnd : cnt_r;
              if (cnt_r == '0) begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end else if (policy_r != bra_pkg::POL_NEXT && st_r > n_eff) begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end else if (policy_r == bra_pkg::POL_BUDDY &&
                           cnt_r > CW'(bra_pkg::BUDDY_MAX_BLOCK)) begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end else if (((policy_r == bra_pkg::POL_BUDDY) ? rnd : cnt_r) > n_eff) begin
                res_status_r <= bra_pkg::ST_NOFIT;
                state_r      <= S_FIN;
              end else begin
                priority case (policy_r)
                  bra_pkg::POL_NEXT:  p_r <= PW'(ptr_r);
                  bra_pkg::POL_BUDDY: p_r <= aligned;
                  default:            p_r <= PW'(st_r);
                endcase
                state_r <= S_RD;
              end
            end
            bra_pkg::CMD_SET: begin
              wr_s_r   <= st_r;
              wr_val_r <= v_r;
              wp_r     <= st_r[OW+AW-1:OW];
              if (policy_r == bra_pkg::POL_BUDDY &&
                  cnt_r > CW'(bra_pkg::BUDDY_MAX_BLOCK)) begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end else if (cnt_r == '0) begin
                state_r <= S_FIN;
                if (st_r > n_eff) res_status_r <= bra_pkg::ST_BAD;
              end else if (st_r > n_eff ||
                  ((policy_r == bra_pkg::POL_BUDDY) ? rnd : cnt_r) > n_eff - st_r) begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end else begin
                wr_e_r  <= st_r + ((policy_r == bra_pkg::POL_BUDDY) ? rnd : cnt_r) - CW'(1);
                state_r <= S_WRD;
              end
            end
            bra_pkg::CMD_TEST: begin
              if (st_r < n_eff) begin
                state_r <= S_TRD;
              end else begin
                res_status_r <= bra_pkg::ST_BAD;
                state_r      <= S_FIN;
              end
            end
            default: begin
              res_status_r <= bra_pkg::ST_BAD;
              state_r      <= S_FIN;
            end
          endcase
        end
        S_RD: begin
          state_r <= (p_r >= PW'(n_eff)) ? S_SEND : S_LD;
        end
        S_LD: begin
          wreg_r  <= rd_word;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          logic hit;
          hit = 1'b0;
          priority case (policy_r)
            bra_pkg::POL_BEST: begin
              c_r <= match ? c_inc : '0;
              if ((!match || p_inc == PW'(n_eff)) && run_r >= len_r &&
                  (!found_r || run_r < best_r)) begin
                found_r    <= 1'b1;
                best_r     <= run_r;
                best_idx_r <= run_s[CW-1:0];
              end
            end
            bra_pkg::POL_BUDDY: begin
              blk_ok_r <= ok_n;
              hit = ok_n && (off == len_r - CW'(1));
            end
            default: begin
              c_r <= match ? c_inc : '0;
              hit = match && (c_inc == len_r);
            end
          endcase
          if (hit) begin
            if (phase2_r && hit_s >= PW'(ptr_r)) begin
              res_status_r <= bra_pkg::ST_NOFIT;
              state_r      <= S_FIN;
            end else begin
              res_idx_r <= hit_s[bra_pkg::IDX_W-1:0];
              wr_s_r    <= hit_s[CW-1:0];
              wr_e_r    <= hit_s[CW-1:0] + len_r - CW'(1);
              wp_r      <= hit_s[OW+AW-1:OW];
              wr_val_r  <= ~v_r;
              if (policy_r == bra_pkg::POL_NEXT)
                ptr_r <= (nf_end >= {1'b0, n_eff}) ? '0 : nf_end[CW-1:0];
              state_r <= S_WRD;
            end
          end else begin
            p_r <= p_inc;
            if (p_inc == PW'(n_eff))           state_r <= S_SEND;
            else if (p_r[OW-1:0] == OW'(WB - 1)) state_r <= S_RD;
          end
        end
        S_SEND: begin
          if (policy_r == bra_pkg::POL_NEXT && !phase2_r && ptr_r != '0) begin
            phase2_r <= 1'b1;
            p_r      <= '0;
            c_r      <= '0;
            state_r  <= S_RD;
          end else if (policy_r == bra_pkg::POL_BEST && found_r) begin
            res_idx_r <= best_idx_r[bra_pkg::IDX_W-1:0];
            wr_s_r    <= best_idx_r;
            wr_e_r    <= best_idx_r + len_r - CW'(1);
            wp_r      <= best_idx_r[OW+AW-1:OW];
            wr_val_r  <= ~v_r;
            state_r   <= S_WRD;
          end else begin
            res_status_r <= bra_pkg::ST_NOFIT;
            state_r      <= S_FIN;
          end
        end
        S_WRD:  state_r <= S_WMOD;
        S_WMOD: begin
          if (wp_r == wr_e_r[OW+AW-1:OW]) begin
            state_r <= S_FIN;
          end else begin
            wp_r    <= wp_r + AW'(1);
            state_r <= S_WRD;
          end
        end
        S_TRD:  state_r <= S_TLD;
        S_TLD: begin
          res_bit_r <= rd_word[st_r[OW-1:0]];
          state_r   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/bra_checker.sv]
`timescale 1ns / 1ps

module bra_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // one request in flight: no second request right after one is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:10] <= bra_pkg::ST_BAD)
    else $error("bad status code");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:10] != bra_pkg::ST_OK |->
      out_tdata[9:0] == 10'd0 && !out_tdata[12])
    else $error("index or bit set on failed request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

endmodule

bind bitmap_run_allocator bra_props u_bra_props (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
